>>> rtl/bzs_pkg.sv
`default_nettype none

package bzs_pkg;

  localparam int COORD_W = 32;
  localparam int T_W     = 17;
  localparam int T_FRAC  = 16;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  // Subdivided curve: up to seven points per request
  localparam int NPTS  = 7;
  localparam int IDX_W = $clog2(NPTS);
  localparam logic [IDX_W-1:0] LAST_CUBIC = IDX_W'(NPTS - 1);
  localparam logic [IDX_W-1:0] LAST_QUAD  = IDX_W'(NPTS - 3);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    CMD_QUAD  = 1'b0,
    CMD_CUBIC = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    cmd_t             cmd;
    point_t [3:0]     p;
    logic [T_W-1:0]   t;
  } item_t;

  typedef struct packed {
    point_t [NPTS-1:0]  pts;
    logic [IDX_W-1:0]   last_idx;
  } bundle_t;

  // a + ((b - a) * t >>> T_FRAC); result stays between a and b for t <= one
  function automatic logic signed [COORD_W-1:0] lerp(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b,
    input logic [T_W-1:0]            t
  );
    logic signed [COORD_W:0]         diff;
    logic signed [COORD_W+T_W+1:0]   prod;
    logic signed [COORD_W+T_W+1:0]   sh;
    diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
    prod = diff * $signed({1'b0, t});
    sh   = prod >>> T_FRAC;
    return a + $signed(sh[COORD_W-1:0]);
  endfunction

  function automatic point_t lerp_pt(input point_t a, input point_t b,
                                     input logic [T_W-1:0] t);
    point_t r;
    r.x = lerp(a.x, b.x, t);
    r.y = lerp(a.y, b.y, t);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bzs_if.sv
`default_nettype none

interface bzs_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] p0_x;
  logic signed [31:0] p0_y;
  logic signed [31:0] p1_x;
  logic signed [31:0] p1_y;
  logic signed [31:0] p2_x;
  logic signed [31:0] p2_y;
  logic signed [31:0] p3_x;
  logic signed [31:0] p3_y;
  logic [16:0]        split_t;

  modport source (output valid, command, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                  p3_x, p3_y, split_t, input ready);
  modport sink   (input valid, command, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                  p3_x, p3_y, split_t, output ready);
endinterface

interface bzs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

>>> rtl/bzs_front.sv
`default_nettype none

module bzs_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bzs_pkg::item_t in_item,
  output logic               q_valid,
  input  wire logic          q_ready,
  output bzs_pkg::item_t     q_item
);
  import bzs_pkg::*;

  item_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  item_t              item_sat;
  logic               push, pop;

  // Clamp t to one
  always_comb begin
    item_sat = in_item;
    if (in_item.t > T_ONE) begin
      item_sat.t = T_ONE;
    end
  end

  assign in_ready = (count_r != QCNT_W'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_sat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bzs_lerp_pipe.sv
`default_nettype none

module bzs_lerp_pipe (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bzs_pkg::item_t in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bzs_pkg::bundle_t   out_bundle
);
  import bzs_pkg::*;

  logic en;

  // Level one
  logic             s1_v_r;
  cmd_t             s1_cmd_r;
  logic [T_W-1:0]   s1_t_r;
  point_t           s1_p0_r, s1_p2_r, s1_p3_r;
  point_t           s1_p01_r, s1_p12_r, s1_p23_r;

  // Level two
  logic             s2_v_r;
  cmd_t             s2_cmd_r;
  logic [T_W-1:0]   s2_t_r;
  point_t           s2_p0_r, s2_p2_r, s2_p3_r;
  point_t           s2_p01_r, s2_p12_r, s2_p23_r;
  point_t           s2_a_r, s2_b_r;

  // Level three
  logic             s3_v_r;
  bundle_t          s3_bundle_r;
  bundle_t          bundle_nxt;
  point_t           mid;

  // Advance the whole pipe together; hold when the last stage is stuck
  assign en         = !s3_v_r || out_ready;
  assign in_ready   = en;
  assign out_valid  = s3_v_r;
  assign out_bundle = s3_bundle_r;

  assign mid = lerp_pt(s2_a_r, s2_b_r, s2_t_r);

  always_comb begin
    bundle_nxt.pts[0] = s2_p0_r;
    bundle_nxt.pts[1] = s2_p01_r;
    bundle_nxt.pts[2] = s2_a_r;
    if (s2_cmd_r == CMD_CUBIC) begin
      bundle_nxt.pts[3]   = mid;
      bundle_nxt.pts[4]   = s2_b_r;
      bundle_nxt.pts[5]   = s2_p23_r;
      bundle_nxt.pts[6]   = s2_p3_r;
      bundle_nxt.last_idx = LAST_CUBIC;
    end else begin
      // Quadratic midpoint comes from level two
      bundle_nxt.pts[3]   = s2_p12_r;
      bundle_nxt.pts[4]   = s2_p2_r;
      bundle_nxt.pts[5]   = s2_p2_r;
      bundle_nxt.pts[6]   = s2_p2_r;
      bundle_nxt.last_idx = LAST_QUAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= in_item.cmd;
      s1_t_r   <= in_item.t;
      s1_p0_r  <= in_item.p[0];
      s1_p2_r  <= in_item.p[2];
      s1_p3_r  <= in_item.p[3];
      s1_p01_r <= lerp_pt(in_item.p[0], in_item.p[1], in_item.t);
      s1_p12_r <= lerp_pt(in_item.p[1], in_item.p[2], in_item.t);
      s1_p23_r <= lerp_pt(in_item.p[2], in_item.p[3], in_item.t);

      s2_cmd_r <= s1_cmd_r;
      s2_t_r   <= s1_t_r;
      s2_p0_r  <= s1_p0_r;
      s2_p2_r  <= s1_p2_r;
      s2_p3_r  <= s1_p3_r;
      s2_p01_r <= s1_p01_r;
      s2_p12_r <= s1_p12_r;
      s2_p23_r <= s1_p23_r;
      s2_a_r   <= lerp_pt(s1_p01_r, s1_p12_r, s1_t_r);
      s2_b_r   <= lerp_pt(s1_p12_r, s1_p23_r, s1_t_r);

      s3_bundle_r <= bundle_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bzs_serial.sv
`default_nettype none

module bzs_serial (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bzs_pkg::bundle_t in_bundle,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bzs_pkg::point_t    out_point,
  output logic               out_last
);
  import bzs_pkg::*;

  logic               valid_r, valid_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  bundle_t            bund_r;
  logic               fire, load;

  assign out_valid = valid_r;
  assign out_point = bund_r.pts[idx_r];
  assign out_last  = (idx_r == bund_r.last_idx);
  assign fire      = valid_r && out_ready;
  // Take the next bundle as the final point of the current one leaves
  assign in_ready  = !valid_r || (fire && out_last);
  assign load      = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (fire) begin
      if (out_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= in_bundle;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bezier_subdivide.sv
`default_nettype none
// Bezier curve split at parameter t (de Casteljau), quadratic or cubic.
// in_ch: one request carries the command, four control points (signed Q16.16)
//   and split_t (unsigned Q1.16, values above one clamp to one). p3 is ignored for a
//   quadratic. A request is taken when valid and ready are both high.
// out_ch: one point per transfer in curve order; last_point marks the final
//   point. A quadratic gives five points, a cubic seven.
// Path: a request passes the queue, the three pipe levels and the serializer
//   register before its first point appears on out_ch.
// Throughput: one point per cycle on out_ch while the receiver holds ready
//   high; the output serializer sets this rate. A two-entry queue and a
//   three-level interpolation pipe keep requests flowing while earlier
//   points are still going out.
// Receiver stall: points hold steady on out_ch, the pipe and then the queue
//   fill, and in_ch ready drops once the queue is full. Nothing is dropped.
// Reset: synchronous, active low; clears the queue, pipe and serializer
//   valids. No clearing pass, the block takes requests right after reset.
module bezier_subdivide (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bzs_in_if.sink     in_ch,
  bzs_out_if.source  out_ch
);
  import bzs_pkg::*;

  item_t    raw_item;
  item_t    q_item;
  logic     q_valid, q_ready;
  bundle_t  pipe_bundle;
  logic     pipe_valid, pipe_ready;
  point_t   out_point;

  always_comb begin
    raw_item.cmd    = cmd_t'(in_ch.command);
    raw_item.p[0].x = in_ch.p0_x;
    raw_item.p[0].y = in_ch.p0_y;
    raw_item.p[1].x = in_ch.p1_x;
    raw_item.p[1].y = in_ch.p1_y;
    raw_item.p[2].x = in_ch.p2_x;
    raw_item.p[2].y = in_ch.p2_y;
    raw_item.p[3].x = in_ch.p3_x;
    raw_item.p[3].y = in_ch.p3_y;
    raw_item.t      = in_ch.split_t;
  end

  bzs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (raw_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  bzs_lerp_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (pipe_valid),
    .out_ready  (pipe_ready),
    .out_bundle (pipe_bundle)
  );

  bzs_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pipe_valid),
    .in_ready  (pipe_ready),
    .in_bundle (pipe_bundle),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_point (out_point),
    .out_last  (out_ch.last_point)
  );

  assign out_ch.point_x = out_point.x;
  assign out_ch.point_y = out_point.y;

endmodule

`default_nettype wire
